// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/jac_pkg.sv =====
// ---------------------------------------------------------------------------
// jac_pkg
// Shared types and constants of the joystick axis calibrator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package jac_pkg;
  localparam int MaxAxes = 8;
  localparam int AxW = $clog2(MaxAxes);
  localparam int CntW = $clog2(MaxAxes + 1);
  localparam int DivW = 31;
  // twice the scale numerator
  localparam logic [DivW-1:0] ScaleNum2 = 31'd1073709056;

  localparam logic [2:0] ReqStart = 3'd0;
  localparam logic [2:0] ReqSample = 3'd1;
  localparam logic [2:0] ReqTimeout = 3'd2;
  localparam logic [2:0] ReqFinish = 3'd3;
  localparam logic [2:0] ReqCancel = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE, PH_CENTRE, PH_COLLECT, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_ACCEPT, ST_LOAD, ST_DIV_LO, ST_DIV_HI, ST_DIV_WAIT, ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic clear_all;
    logic do_centre;
    logic do_range;
    logic fill_centre;
    logic load_axis;
    logic div_start_lo;
    logic div_start_hi;
  } dp_cmd_t;

  typedef struct packed {
    logic usable;
    logic div_done;
  } dp_stat_t;
endpackage

// ===== rtl/joystick_axis_calibrator.sv =====
// Finish walks the axes in use: each usable axis runs two 31-bit divisions
//   (one quotient bit per cycle), a keep-original axis skips them, and an emit
//   waits while the output register is stalled.
// Outside finish, requests are accepted at one request per cycle.
// Input is stalled for the whole walk.
// Synchronous active-low reset: phase idle, axis count 8, seen flags cleared.
// ---------------------------------------------------------------------------
// joystick_axis_calibrator
// Top level: configuration register, controller, datapath and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module joystick_axis_calibrator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_axes_in_use,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic               in_is_axis_event,
  input  logic [7:0]         in_axis_index,
  input  logic signed [15:0] in_sample_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_out_axis,
  output logic               out_corr_kind,
  output logic [14:0]        out_precision,
  output logic signed [15:0] out_band_low,
  output logic signed [15:0] out_band_high,
  output logic [27:0]        out_lower_scale,
  output logic [27:0]        out_upper_scale,
  output logic               out_last,
  output logic               out_outcome
);
  logic [3:0] axes_r;
  jac_pkg::dp_cmd_t cmd;
  jac_pkg::dp_stat_t stat;
  logic [jac_pkg::AxW-1:0] walk_axis;
  logic emit, res_last, res_outcome, res_kind, ovalid_r, out_busy;
  logic [14:0] res_prec;
  logic signed [15:0] res_blo, res_bhi;
  logic [27:0] res_lsc, res_usc;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) axes_r <= 4'd8;
    else if (cfg_valid && cfg_ready) axes_r <= cfg_axes_in_use;
  end

  assign out_busy = ovalid_r && out_stall;

  jac_controller u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_is_axis_event(in_is_axis_event),
    .in_axis_index(in_axis_index), .axes_r(axes_r), .cmd(cmd), .stat(stat),
    .walk_axis(walk_axis), .emit(emit), .out_busy(out_busy),
    .res_last(res_last), .res_outcome(res_outcome)
  );

  jac_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .samp_axis(in_axis_index[jac_pkg::AxW-1:0]),
    .samp_value(in_sample_value), .walk_axis(walk_axis), .stat(stat),
    .res_kind(res_kind), .res_precision(res_prec), .res_band_low(res_blo),
    .res_band_high(res_bhi), .res_lower_scale(res_lsc), .res_upper_scale(res_usc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (emit) ovalid_r <= 1'b1;
    else if (!out_stall) ovalid_r <= 1'b0;
    if (emit) begin
      out_out_axis <= 3'(walk_axis);
      out_corr_kind <= res_kind;
      out_precision <= res_prec;
      out_band_low <= res_blo;
      out_band_high <= res_bhi;
      out_lower_scale <= res_lsc;
      out_upper_scale <= res_usc;
      out_last <= res_last;
      out_outcome <= res_outcome;
    end
  end
  assign out_valid = ovalid_r;
endmodule

// ===== rtl/jac_divider.sv =====
// ---------------------------------------------------------------------------
// jac_divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module jac_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [jac_pkg::DivW-1:0] dividend,
  input  logic [jac_pkg::DivW-1:0] divisor,
  output logic                     done,
  output logic [jac_pkg::DivW-1:0] quotient
);
  logic [jac_pkg::DivW-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [jac_pkg::DivW:0]   rem_r, rem_nxt, trial;
  logic [4:0]               cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt = q_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[jac_pkg::DivW-1:0], q_r[jac_pkg::DivW-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend;
      d_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = 5'(jac_pkg::DivW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[jac_pkg::DivW]) begin
        rem_nxt = trial;
        q_nxt = {q_r[jac_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[jac_pkg::DivW-1:0], q_r[jac_pkg::DivW-1]};
        q_nxt = {q_r[jac_pkg::DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule

// ===== rtl/jac_datapath.sv =====
// ---------------------------------------------------------------------------
// jac_datapath
// Per-axis band and range records, result assembly and scale division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module jac_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  jac_pkg::dp_cmd_t          cmd,
  input  logic [jac_pkg::AxW-1:0]   samp_axis,
  input  logic signed [15:0]        samp_value,
  input  logic [jac_pkg::AxW-1:0]   walk_axis,
  output jac_pkg::dp_stat_t         stat,
  output logic                      res_kind,
  output logic [14:0]               res_precision,
  output logic signed [15:0]        res_band_low,
  output logic signed [15:0]        res_band_high,
  output logic [27:0]               res_lower_scale,
  output logic [27:0]               res_upper_scale
);
  logic signed [15:0] clo_r [jac_pkg::MaxAxes];
  logic signed [15:0] chi_r [jac_pkg::MaxAxes];
  logic signed [15:0] rmin_r [jac_pkg::MaxAxes];
  logic signed [15:0] rmax_r [jac_pkg::MaxAxes];
  logic [jac_pkg::MaxAxes-1:0] cseen_r, rseen_r;
  logic signed [16:0] lo_rng_r, hi_rng_r, width_r;
  logic usable_r, rseen_sel;
  logic signed [15:0] blo_r, bhi_r;
  logic [27:0] lsc_r, usc_r;
  logic [jac_pkg::DivW-1:0] divisor, quot;
  logic div_done;

  always_ff @(posedge clk) begin
    if (cmd.do_centre) begin
      if (!cseen_r[samp_axis] || samp_value < clo_r[samp_axis]) clo_r[samp_axis] <= samp_value;
      if (!cseen_r[samp_axis] || samp_value > chi_r[samp_axis]) chi_r[samp_axis] <= samp_value;
    end
    if (cmd.do_range) begin
      if (!rseen_r[samp_axis] || samp_value < rmin_r[samp_axis]) rmin_r[samp_axis] <= samp_value;
      if (!rseen_r[samp_axis] || samp_value > rmax_r[samp_axis]) rmax_r[samp_axis] <= samp_value;
    end
    if (cmd.fill_centre) begin
      for (int i = 0; i < jac_pkg::MaxAxes; i++) begin
        if (!cseen_r[i]) begin
          clo_r[i] <= '0;
          chi_r[i] <= '0;
        end
      end
    end
    if (!rst_n || cmd.clear_all) begin
      cseen_r <= '0;
      rseen_r <= '0;
    end else begin
      if (cmd.do_centre) cseen_r[samp_axis] <= 1'b1;
      if (cmd.do_range) rseen_r[samp_axis] <= 1'b1;
      if (cmd.fill_centre) cseen_r <= '1;
    end
  end

  assign rseen_sel = rseen_r[walk_axis];

  // capture one axis for the walk
  always_ff @(posedge clk) begin
    if (cmd.load_axis) begin
      lo_rng_r <= 17'(clo_r[walk_axis]) - 17'(rmin_r[walk_axis]);
      hi_rng_r <= 17'(rmax_r[walk_axis]) - 17'(chi_r[walk_axis]);
      width_r <= 17'(chi_r[walk_axis]) - 17'(clo_r[walk_axis]);
      blo_r <= clo_r[walk_axis];
      bhi_r <= chi_r[walk_axis];
      usable_r <= rseen_sel;
    end
  end

  logic usable;
  assign usable = usable_r && (lo_rng_r > 17'sd1) && (hi_rng_r > 17'sd1);
  assign divisor = cmd.div_start_hi ? {13'd0, hi_rng_r[16:0], 1'b0}
                                    : {13'd0, lo_rng_r[16:0], 1'b0};

  jac_divider u_div (
    .clk(clk), .rst_n(rst_n),
    .start(cmd.div_start_lo || cmd.div_start_hi),
    .dividend(jac_pkg::ScaleNum2 + (cmd.div_start_hi ? jac_pkg::DivW'(hi_rng_r)
                                                     : jac_pkg::DivW'(lo_rng_r))),
    .divisor(divisor), .done(div_done), .quotient(quot)
  );

  logic which_r;
  always_ff @(posedge clk) begin
    if (cmd.div_start_lo) which_r <= 1'b0;
    if (cmd.div_start_hi) which_r <= 1'b1;
    if (div_done) begin
      if (which_r) usc_r <= quot[27:0];
      else lsc_r <= quot[27:0];
    end
  end

  assign stat.usable = usable;
  assign stat.div_done = div_done;
  assign res_kind = usable;
  assign res_precision = !usable ? 15'd0 : width_r[16] ? 15'd0 :
                         (width_r[15] ? 15'h7fff : width_r[14:0]);
  assign res_band_low = usable ? blo_r : 16'sd0;
  assign res_band_high = usable ? bhi_r : 16'sd0;
  assign res_lower_scale = usable ? lsc_r : 28'd0;
  assign res_upper_scale = usable ? usc_r : 28'd0;
endmodule

// ===== rtl/jac_controller.sv =====
// ---------------------------------------------------------------------------
// jac_controller
// Phase tracking, request decode and the finish walk over the axes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module jac_controller (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_req_type,
  input  logic                    in_is_axis_event,
  input  logic [7:0]              in_axis_index,
  input  logic [3:0]              axes_r,
  output jac_pkg::dp_cmd_t        cmd,
  input  jac_pkg::dp_stat_t       stat,
  output logic [jac_pkg::AxW-1:0] walk_axis,
  output logic                    emit,
  input  logic                    out_busy,
  output logic                    res_last,
  output logic                    res_outcome
);
  jac_pkg::phase_t phase_r, phase_nxt;
  jac_pkg::ctl_state_t state_r, state_nxt;
  logic [jac_pkg::AxW-1:0] ax_r, ax_nxt;
  logic [jac_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic [jac_pkg::CntW-1:0] n_act;
  logic acc, samp_ok, is_last;

  assign n_act = (axes_r == 4'd0) ? jac_pkg::CntW'(1) :
                 (axes_r > 4'(jac_pkg::MaxAxes)) ? jac_pkg::CntW'(jac_pkg::MaxAxes) :
                 jac_pkg::CntW'(axes_r);
  assign in_stall = (state_r != jac_pkg::ST_ACCEPT);
  assign acc = in_valid && !in_stall;
  assign samp_ok = in_is_axis_event && ({1'b0, in_axis_index} < 9'(n_act));
  assign is_last = (jac_pkg::CntW'(ax_r) == n_act - jac_pkg::CntW'(1));
  assign walk_axis = ax_r;
  assign res_last = is_last;
  assign res_outcome = is_last && (cnt_r == '0) && !stat.usable;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jac_pkg::PH_IDLE;
      state_r <= jac_pkg::ST_ACCEPT;
      ax_r <= '0;
      cnt_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      state_r <= state_nxt;
      ax_r <= ax_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    state_nxt = state_r;
    ax_nxt = ax_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    emit = 1'b0;
    case (state_r)
      jac_pkg::ST_ACCEPT: begin
        if (acc) begin
          case (in_req_type)
            jac_pkg::ReqStart: begin
              if (phase_r != jac_pkg::PH_CENTRE && phase_r != jac_pkg::PH_COLLECT) begin
                cmd.clear_all = 1'b1;
                phase_nxt = jac_pkg::PH_CENTRE;
              end
            end
            jac_pkg::ReqSample: begin
              cmd.do_centre = samp_ok && (phase_r == jac_pkg::PH_CENTRE);
              cmd.do_range = samp_ok && (phase_r == jac_pkg::PH_COLLECT);
            end
            jac_pkg::ReqTimeout: begin
              if (phase_r == jac_pkg::PH_CENTRE) begin
                cmd.fill_centre = 1'b1;
                phase_nxt = jac_pkg::PH_COLLECT;
              end
            end
            jac_pkg::ReqFinish: begin
              if (phase_r == jac_pkg::PH_COLLECT) begin
                ax_nxt = '0;
                cnt_nxt = '0;
                state_nxt = jac_pkg::ST_LOAD;
              end
            end
            jac_pkg::ReqCancel: phase_nxt = jac_pkg::PH_IDLE;
            default: ;
          endcase
        end
      end
      jac_pkg::ST_LOAD: begin
        cmd.load_axis = 1'b1;
        state_nxt = jac_pkg::ST_DIV_LO;
      end
      jac_pkg::ST_DIV_LO: begin
        if (!stat.usable) state_nxt = jac_pkg::ST_EMIT;
        else begin
          cmd.div_start_lo = 1'b1;
          state_nxt = jac_pkg::ST_DIV_HI;
        end
      end
      jac_pkg::ST_DIV_HI: begin
        if (stat.div_done) begin
          cmd.div_start_hi = 1'b1;
          state_nxt = jac_pkg::ST_DIV_WAIT;
        end
      end
      // hold until the upper scale is captured
      jac_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) state_nxt = jac_pkg::ST_EMIT;
      end
      jac_pkg::ST_EMIT: begin
        if (!out_busy) emit = 1'b1;
        if (emit) begin
          if (stat.usable) cnt_nxt = jac_pkg::CntW'(1) | cnt_r;
          if (is_last) begin
            state_nxt = jac_pkg::ST_ACCEPT;
            phase_nxt = (cnt_r != '0 || stat.usable) ? jac_pkg::PH_DONE : jac_pkg::PH_ERROR;
          end else begin
            ax_nxt = ax_r + jac_pkg::AxW'(1);
            state_nxt = jac_pkg::ST_LOAD;
          end
        end
      end
      default: state_nxt = jac_pkg::ST_ACCEPT;
    endcase
  end
endmodule

// ===== rtl/jac_checker.sv =====
// ---------------------------------------------------------------------------
// jac_checker
// Port-level checks of the calibrator's request and result channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_last,
  input logic        out_outcome,
  input logic        out_corr_kind,
  input logic [27:0] out_lower_scale
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_IMPL(a_outcome_last, clk, rst_n, out_valid && out_outcome, out_last)
  `ASSERT_IMPL(a_keep_zero, clk, rst_n, out_valid && !out_corr_kind, out_lower_scale == 28'd0)
  `ASSERT_IMPL(a_stall_out, clk, rst_n, out_valid && !out_last, in_stall)
endmodule

bind joystick_axis_calibrator jac_checker u_jac_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_last(out_last), .out_outcome(out_outcome),
  .out_corr_kind(out_corr_kind), .out_lower_scale(out_lower_scale)
);

// ===== verif/tb_joystick_axis_calibrator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_joystick_axis_calibrator
// Self-checking bench for the axis calibrator. Requests are driven with random
// gaps and result stalls. A behavioral predictor tracks centre bands and axis
// ranges and queues the corrections a finish produces. Each emitted
// correction is compared field by field in order.
// ---------------------------------------------------------------------------
module tb_joystick_axis_calibrator;
  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles = 10;
  localparam int EndCycles = 600;
  localparam logic [63:0] ScaleNumer = 64'd536854528;

  typedef struct {
    logic [2:0]         axis;
    logic               kind;
    logic [14:0]        precision;
    logic signed [15:0] band_low;
    logic signed [15:0] band_high;
    logic [27:0]        lower_scale;
    logic [27:0]        upper_scale;
    logic               last;
    logic               outcome;
  } correction_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_axes_in_use = 4'd8;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = jac_pkg::ReqCancel;
  logic in_is_axis_event = 1'b0;
  logic [7:0] in_axis_index = 8'd0;
  logic signed [15:0] in_sample_value = 16'sd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_out_axis;
  logic out_corr_kind;
  logic [14:0] out_precision;
  logic signed [15:0] out_band_low;
  logic signed [15:0] out_band_high;
  logic [27:0] out_lower_scale;
  logic [27:0] out_upper_scale;
  logic out_last;
  logic out_outcome;

  joystick_axis_calibrator u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_axes_in_use(cfg_axes_in_use),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_is_axis_event(in_is_axis_event), .in_axis_index(in_axis_index),
    .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_out_axis(out_out_axis),
    .out_corr_kind(out_corr_kind), .out_precision(out_precision),
    .out_band_low(out_band_low), .out_band_high(out_band_high),
    .out_lower_scale(out_lower_scale), .out_upper_scale(out_upper_scale),
    .out_last(out_last), .out_outcome(out_outcome)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [3:0] axes_reg = 4'd8;
  jac_pkg::phase_t cal_phase = jac_pkg::PH_IDLE;
  logic signed [15:0] band_lo_q [jac_pkg::MaxAxes];
  logic signed [15:0] band_hi_q [jac_pkg::MaxAxes];
  logic centre_hit [jac_pkg::MaxAxes];
  logic signed [15:0] min_q [jac_pkg::MaxAxes];
  logic signed [15:0] max_q [jac_pkg::MaxAxes];
  logic range_hit [jac_pkg::MaxAxes];

  correction_t pending_corrections[$];
  int error_count = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic int axes_active();
    if (axes_reg < 1) return 1;
    if (axes_reg > jac_pkg::MaxAxes) return jac_pkg::MaxAxes;
    return int'(axes_reg);
  endfunction

  function automatic logic [27:0] broken_line_scale(int span);
    logic [63:0] r;
    r = span;
    return 28'(((64'd2 * ScaleNumer) + r) / (64'd2 * r));
  endfunction

  function automatic void predict_request(logic [2:0] req, logic ev, logic [7:0] ax,
                                          logic signed [15:0] val);
    int n;
    int usable;
    int lo_span;
    int hi_span;
    int width;
    correction_t c;
    n = axes_active();
    case (req)
      jac_pkg::ReqStart: begin
        if (cal_phase != jac_pkg::PH_CENTRE && cal_phase != jac_pkg::PH_COLLECT) begin
          foreach (centre_hit[i]) begin
            centre_hit[i] = 1'b0;
            range_hit[i] = 1'b0;
          end
          cal_phase = jac_pkg::PH_CENTRE;
        end
      end
      jac_pkg::ReqSample: begin
        if (ev && int'(ax) < n) begin
          if (cal_phase == jac_pkg::PH_CENTRE) begin
            if (!centre_hit[ax] || val < band_lo_q[ax]) band_lo_q[ax] = val;
            if (!centre_hit[ax] || val > band_hi_q[ax]) band_hi_q[ax] = val;
            centre_hit[ax] = 1'b1;
          end else if (cal_phase == jac_pkg::PH_COLLECT) begin
            if (!range_hit[ax] || val < min_q[ax]) min_q[ax] = val;
            if (!range_hit[ax] || val > max_q[ax]) max_q[ax] = val;
            range_hit[ax] = 1'b1;
          end
        end
      end
      jac_pkg::ReqTimeout: begin
        if (cal_phase == jac_pkg::PH_CENTRE) begin
          foreach (centre_hit[i]) if (!centre_hit[i]) begin
            band_lo_q[i] = 16'sd0;
            band_hi_q[i] = 16'sd0;
            centre_hit[i] = 1'b1;
          end
          cal_phase = jac_pkg::PH_COLLECT;
        end
      end
      jac_pkg::ReqFinish: begin
        if (cal_phase == jac_pkg::PH_COLLECT) begin
          usable = 0;
          for (int i = 0; i < n; i++) begin
            c = '{axis: 3'(i), kind: 1'b0, precision: '0, band_low: '0, band_high: '0,
                  lower_scale: '0, upper_scale: '0, last: 1'b0, outcome: 1'b0};
            if (range_hit[i]) begin
              lo_span = int'(band_lo_q[i]) - int'(min_q[i]);
              hi_span = int'(max_q[i]) - int'(band_hi_q[i]);
              if (lo_span > 1 && hi_span > 1) begin
                width = int'(band_hi_q[i]) - int'(band_lo_q[i]);
                if (width < 0) width = 0;
                if (width > 32767) width = 32767;
                c.kind = 1'b1;
                c.precision = 15'(width);
                c.band_low = band_lo_q[i];
                c.band_high = band_hi_q[i];
                c.lower_scale = broken_line_scale(lo_span);
                c.upper_scale = broken_line_scale(hi_span);
                usable++;
              end
            end
            if (i == n - 1) begin
              c.last = 1'b1;
              c.outcome = (usable == 0);
            end
            pending_corrections.push_back(c);
          end
          cal_phase = (usable == 0) ? jac_pkg::PH_ERROR : jac_pkg::PH_DONE;
        end
      end
      jac_pkg::ReqCancel: cal_phase = jac_pkg::PH_IDLE;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    correction_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_corrections.size() == 0) begin
        report_mismatch("unexpected result, axis", out_out_axis, -1);
      end else begin
        e = pending_corrections.pop_front();
        if (out_out_axis !== e.axis) report_mismatch("out_axis", out_out_axis, e.axis);
        if (out_corr_kind !== e.kind) report_mismatch("corr_kind", out_corr_kind, e.kind);
        if (out_precision !== e.precision)
          report_mismatch("precision", out_precision, e.precision);
        if (out_band_low !== e.band_low)
          report_mismatch("band_low", out_band_low, e.band_low);
        if (out_band_high !== e.band_high)
          report_mismatch("band_high", out_band_high, e.band_high);
        if (out_lower_scale !== e.lower_scale)
          report_mismatch("lower_scale", out_lower_scale, e.lower_scale);
        if (out_upper_scale !== e.upper_scale)
          report_mismatch("upper_scale", out_upper_scale, e.upper_scale);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
        if (out_outcome !== e.outcome) report_mismatch("outcome", out_outcome, e.outcome);
      end
    end
  end

  // result-side stall, with an optional long hold counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_req = 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // watchdog on handshake progress
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(logic [2:0] req, logic ev, logic [7:0] ax,
                              logic signed [15:0] val);
    if ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_is_axis_event <= ev;
    in_axis_index <= ax;
    in_sample_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req, ev, ax, val);
  endtask

  task automatic sample(int ax, int val);
    send_request(jac_pkg::ReqSample, 1'b1, 8'(ax), 16'(val));
  endtask

  // hold off until every correction has arrived and the block settles
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_corrections.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_axes(logic [3:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_axes_in_use <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    axes_reg = value;
  endtask

  task automatic noise_request();
    logic [2:0] req;
    req = 3'($urandom_range(7));
    send_request(req, 1'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // well-formed calibration with random content and occasional noise
  task automatic calibration_pass();
    int n;
    int ax;
    n = axes_active();
    send_request(jac_pkg::ReqStart, 1'b0, 8'($urandom), 16'($urandom));
    repeat ($urandom_range(6)) begin
      ax = $urandom_range(n - 1);
      sample(ax, $signed(16'($urandom_range(800))) - 400);
    end
    if ($urandom_range(9) == 0) noise_request();
    send_request(jac_pkg::ReqTimeout, 1'($urandom), 8'($urandom), 16'($urandom));
    repeat ($urandom_range(20, 4)) begin
      if ($urandom_range(9) == 0) noise_request();
      else sample($urandom_range(n - 1), $signed(16'($urandom)));
    end
    send_request(jac_pkg::ReqFinish, 1'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    write_axes(4'd8);
    send_request(jac_pkg::ReqCancel, 1'b0, 8'd0, 16'sd0);
    send_request(3'd5, 1'b1, 8'd0, 16'sd0);
    send_request(3'd6, 1'b1, 8'd0, 16'sd0);
    send_request(3'd7, 1'b1, 8'd0, 16'sd0);
    sample(0, 100);
    send_request(jac_pkg::ReqTimeout, 1'b0, 8'd0, 16'sd0);
    send_request(jac_pkg::ReqFinish, 1'b0, 8'd0, 16'sd0);
    send_request(jac_pkg::ReqStart, 1'b0, 8'd0, 16'sd0);
    send_request(jac_pkg::ReqStart, 1'b0, 8'd0, 16'sd0);
    sample(0, -5);
    sample(0, 5);
    sample(1, 32767);
    send_request(jac_pkg::ReqSample, 1'b0, 8'd2, 16'sd99);
    send_request(jac_pkg::ReqSample, 1'b1, 8'd255, -16'sd1);
    send_request(jac_pkg::ReqSample, 1'b1, 8'd8, 16'sd7);
    send_request(jac_pkg::ReqTimeout, 1'b0, 8'd0, 16'sd0);
    send_request(jac_pkg::ReqTimeout, 1'b0, 8'd0, 16'sd0);
    sample(0, -32768);
    sample(0, 32767);
    sample(1, -32768);
    sample(2, -2);
    sample(2, 2);
    sample(3, -1);
    sample(3, 1);
    send_request(jac_pkg::ReqFinish, 1'b0, 8'd0, 16'sd0);
    // no usable axis ends in the error phase; restart from there
    send_request(jac_pkg::ReqStart, 1'b0, 8'd0, 16'sd0);
    send_request(jac_pkg::ReqTimeout, 1'b0, 8'd0, 16'sd0);
    send_request(jac_pkg::ReqFinish, 1'b0, 8'd0, 16'sd0);
    send_request(jac_pkg::ReqStart, 1'b0, 8'd0, 16'sd0);
    send_request(jac_pkg::ReqCancel, 1'b0, 8'd0, 16'sd0);
  endtask

  task automatic test_axis_counts();
    write_axes(4'd0);
    calibration_pass();
    write_axes(4'd15);
    calibration_pass();
    write_axes(4'd1);
    calibration_pass();
  endtask

  task automatic test_random(int gap_pct, int stall_pct, int passes);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    repeat (passes) begin
      if ($urandom_range(3) == 0) write_axes(4'($urandom_range(8, 1)));
      calibration_pass();
      if ($urandom_range(2) == 0) repeat ($urandom_range(3)) noise_request();
    end
  endtask

  task automatic test_backpressure();
    in_gap_pct = 0;
    out_stall_pct = 0;
    write_axes(4'd8);
    hold_req = 1'b1;
    calibration_pass();
    calibration_pass();
    wait_idle();
    calibration_pass();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_axis_counts();
    test_random(6, 49, 4);
    test_random(49, 6, 4);
    test_random(0, 0, 4);
    test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_corrections.size() != 0) @(posedge clk);
    repeat (EndCycles) @(posedge clk);
    if (error_count == 0 && pending_corrections.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jac_pkg.sv
rtl/jac_divider.sv
rtl/jac_datapath.sv
rtl/jac_controller.sv
rtl/joystick_axis_calibrator.sv
rtl/jac_checker.sv
verif/tb_joystick_axis_calibrator.sv
